### src/asrc_pkg.sv
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared types and constants of the audio sample rate converter.
// ----------------------------------------------------------------------------
package asrc_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int POINT_W    = 6;
   localparam int STEP_W     = 12;
   localparam int LIMIT_W    = 21;
   localparam int CSR_DATA_W = 21;
   localparam int CSR_ADDR_W = 3;

   // position accumulator, unsigned 24.8 with integer part above the fraction
   localparam int POS_W  = 32;
   localparam int FRAC_W = 8;

   // clamps and limits
   localparam int MIN_STEP  = 4;
   localparam int MAX_BURST = 64;
   localparam int BURST_W   = 7;

   // divider of a sample difference by the point count
   localparam int DIVD_W    = 17;
   localparam int REM_W     = 7;
   localparam int QUO_W     = 18;
   localparam int DIV_CNT_W = 5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_RATE_MODE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_FIXED    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INTERP_POINTS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_IS_WIDE    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_IS_WIDE   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_LIMIT     = 3'd5;

   // conversion modes
   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_LINEAR  = 1'b1;

   // effective configuration seen by the front and back
   typedef struct packed {
      logic                rate_mode;
      logic                in_is_wide;
      logic                out_is_wide;
      logic [POINT_W-1:0]  points;
      logic [STEP_W-1:0]   step;
      logic [LIMIT_W-1:0]  out_limit;
   } asrc_cfg_type;

   // one classified item in the queue between front and back
   typedef struct packed {
      logic                mode;
      logic                has_interp;
      logic                last;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] base;
      logic [QUO_W-1:0]    qd;
      logic [POINT_W-1:0]  rd;
   } asrc_entry_type;

endpackage

### src/asrc_if.sv
// ----------------------------------------------------------------------------
// asrc_if
// Valid/ready channels for input samples and converted samples.
// ----------------------------------------------------------------------------
interface asrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [asrc_pkg::SAMPLE_W-1:0] in_sample;
   logic                          in_last;

   modport source (output valid, output in_sample, output in_last, input ready);
   modport sink   (input valid, input in_sample, input in_last, output ready);
endinterface

interface asrc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [asrc_pkg::SAMPLE_W-1:0] out_sample;
   logic                                 out_last;

   modport source (output valid, output out_sample, output out_last, input ready);
   modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

### src/asrc_front.sv
// ----------------------------------------------------------------------------
// asrc_front
// Accepts, widens and queues samples; in linear mode it keeps the held sample
// and, once one is held, first divides the step to the next by the point count.
// ----------------------------------------------------------------------------
module asrc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  asrc_pkg::asrc_cfg_type   cfg,
   asrc_req_if.sink                 req,
   output logic                     push,
   output asrc_pkg::asrc_entry_type push_entry,
   input  logic                     full
);
   import asrc_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [SAMPLE_W-1:0]  held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   asrc_entry_type       entry_ff, entry_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [SAMPLE_W-1:0]  wide_s;
   logic [DIVD_W-1:0]    diff;
   logic [DIVD_W-1:0]    mag;
   logic [REM_W-1:0]     trial;
   logic                 take;
   logic [QUO_W-1:0]     qmag;
   logic                 rem_nz;
   logic [QUO_W-1:0]     qd_val;
   logic [POINT_W-1:0]   rd_val;
   logic                 interp_now;

   // widen to signed 16 bits: offset-binary byte goes to the high byte
   assign wide_s = cfg.in_is_wide ? req.in_sample
                                  : {req.in_sample[7:0] ^ 8'h80, 8'h00};

   // difference toward the new sample and its magnitude
   assign diff = {wide_s[SAMPLE_W-1], wide_s} - {held_ff[SAMPLE_W-1], held_ff};
   assign mag  = diff[DIVD_W-1] ? (~diff + DIVD_W'(1)) : diff;

   // one restoring step per cycle
   assign trial = {rem_ff[REM_W-2:0], quo_ff[DIVD_W-1]};
   assign take  = trial >= {1'b0, cfg.points};

   // floor quotient and non-negative remainder from the magnitude result
   assign qmag   = {1'b0, quo_ff};
   assign rem_nz = rem_ff != '0;
   assign qd_val = neg_ff ? (~qmag + QUO_W'(!rem_nz)) : qmag;
   assign rd_val = (neg_ff && rem_nz) ? (cfg.points - rem_ff[POINT_W-1:0])
                                      : rem_ff[POINT_W-1:0];

   assign interp_now = (cfg.rate_mode == MODE_LINEAR) && held_valid_ff;

   // handshake
   assign req.ready = state_ff == F_IDLE;
   assign push      = (state_ff == F_PUSH) && !full;

   always_comb begin
      push_entry    = entry_ff;
      push_entry.qd = entry_ff.has_interp ? qd_val : '0;
      push_entry.rd = entry_ff.has_interp ? rd_val : '0;
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      entry_in      = entry_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               entry_in.mode       = cfg.rate_mode;
               entry_in.has_interp = interp_now;
               entry_in.last       = req.in_last;
               entry_in.sample     = wide_s;
               entry_in.base       = held_ff;
               entry_in.qd         = '0;
               entry_in.rd         = '0;
               if (cfg.rate_mode == MODE_LINEAR) begin
                  held_in       = req.in_last ? '0 : wide_s;
                  held_valid_in = !req.in_last;
               end
               if (interp_now) begin
                  neg_in   = diff[DIVD_W-1];
                  quo_in   = mag;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = F_DIV;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_DIV: begin
            rem_in = take ? (trial - {1'b0, cfg.points}) : trial;
            quo_in = {quo_ff[DIVD_W-2:0], take};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIVD_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload and divider datapath
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
   end

`ifndef NO_ASSERTIONS
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == F_DIV |-> cnt_ff < DIV_CNT_W'(DIVD_W))
      else $error("divider ran past its last step");
   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      !held_valid_ff |-> held_ff == '0)
      else $error("held sample not cleared");
`endif

endmodule

### src/asrc_queue.sv
// ----------------------------------------------------------------------------
// asrc_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module asrc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  asrc_pkg::asrc_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output asrc_pkg::asrc_entry_type pop_entry
);
   import asrc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   asrc_entry_type   store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(DEPTH)) || pop)
      else $error("queue written while full");
`endif

endmodule

### src/asrc_back.sv
// ----------------------------------------------------------------------------
// asrc_back
// Carries out queued items: interpolated and flat points in linear mode,
// position-accumulator selection in nearest mode, one output per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module asrc_back #(
   parameter int MAX_SAMPLES = 1048576
) (
   input  logic                     clock,
   input  logic                     reset,
   input  asrc_pkg::asrc_cfg_type   cfg,
   input  logic                     q_valid,
   input  asrc_pkg::asrc_entry_type q_entry,
   output logic                     q_pop,
   asrc_rsp_if.source               rsp
);
   import asrc_pkg::*;

   localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
   localparam int LIM_W = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
   localparam int CMP_W = (IDX_W > POS_W - FRAC_W) ? IDX_W : POS_W - FRAC_W;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SAMPLES);

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_INTERP = 4'b0010,
      B_FLAT   = 4'b0100,
      B_NEAR   = 4'b1000
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [QUO_W-1:0]    q_ff, q_in;
   logic [REM_W-1:0]    r_ff, r_in;
   logic [QUO_W-1:0]    qd_ff, qd_in;
   logic [POINT_W-1:0]  rd_ff, rd_in;
   logic [POINT_W-1:0]  j_ff, j_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_ff, last_in;
   logic [BURST_W-1:0]  burst_ff, burst_in;
   logic [IDX_W-1:0]    input_index_ff, input_index_in;
   logic [IDX_W-1:0]    output_index_ff, output_index_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LIM_W-1:0]    lim;
   logic                can_emit;
   logic                bump;
   logic [QUO_W-1:0]    adj;
   logic [REM_W-1:0]    r_sum;
   logic                wrap;
   logic [REM_W-1:0]    r_next;
   logic [QUO_W-1:0]    q_next;
   logic                near_cond;
   logic                near_last;
   logic [IDX_W-1:0]    idx_inc;
   logic                end_point;
   logic                emit;
   logic [SAMPLE_W-1:0] emit_val;
   logic                emit_last;

   assign lim = (LIM_W'(cfg.out_limit) > LIM_W'(MAX_SAMPLES)) ? LIM_W'(MAX_SAMPLES)
                                                              : LIM_W'(cfg.out_limit);

   // output register frees up when empty or being taken
   assign can_emit = !rsp_valid_ff || rsp.ready;

   // truncate toward zero: floor plus one for a negative inexact quotient
   assign bump = (r_ff != '0) && q_ff[QUO_W-1];
   assign adj  = q_ff + QUO_W'(bump);

   // running quotient and remainder of the next point
   assign r_sum  = r_ff + {1'b0, rd_ff};
   assign wrap   = r_sum >= {1'b0, cfg.points};
   assign r_next = wrap ? (r_sum - {1'b0, cfg.points}) : r_sum;
   assign q_next = q_ff + qd_ff + QUO_W'(wrap);

   assign end_point = j_ff == (cfg.points - POINT_W'(1));

   // nearest mode selection
   assign near_cond = (burst_ff != BURST_W'(MAX_BURST))
                      && (LIM_W'(output_index_ff) < lim)
                      && (CMP_W'(pos_ff[POS_W-1:FRAC_W]) == CMP_W'(input_index_ff));
   assign near_last = LIM_W'(output_index_ff) == (lim - LIM_W'(1));

   assign idx_inc = (input_index_ff != MAX_IDX) ? input_index_ff + IDX_W'(1)
                                                : input_index_ff;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      qd_in           = qd_ff;
      rd_in           = rd_ff;
      j_in            = j_ff;
      sample_in       = sample_ff;
      last_in         = last_ff;
      burst_in        = burst_ff;
      input_index_in  = input_index_ff;
      output_index_in = output_index_ff;
      pos_in          = pos_ff;
      q_pop           = 1'b0;
      emit            = 1'b0;
      emit_val        = adj[SAMPLE_W-1:0];
      emit_last       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               sample_in = q_entry.sample;
               last_in   = q_entry.last;
               j_in      = '0;
               r_in      = '0;
               burst_in  = '0;
               if (q_entry.mode == MODE_LINEAR) begin
                  if (q_entry.has_interp) begin
                     q_in     = {{(QUO_W-SAMPLE_W){q_entry.base[SAMPLE_W-1]}}, q_entry.base};
                     qd_in    = q_entry.qd;
                     rd_in    = q_entry.rd;
                     state_in = B_INTERP;
                  end else if (q_entry.last) begin
                     q_in     = {{(QUO_W-SAMPLE_W){q_entry.sample[SAMPLE_W-1]}},
                                 q_entry.sample};
                     qd_in    = '0;
                     rd_in    = '0;
                     state_in = B_FLAT;
                  end else begin
                     input_index_in = idx_inc;
                  end
               end else if (input_index_ff != MAX_IDX) begin
                  state_in = B_NEAR;
               end else if (q_entry.last) begin
                  input_index_in  = '0;
                  output_index_in = '0;
                  pos_in          = '0;
               end
            end
         end
         B_INTERP: begin
            if (can_emit) begin
               emit = 1'b1;
               if (end_point) begin
                  if (last_ff) begin
                     q_in     = {{(QUO_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
                     r_in     = '0;
                     qd_in    = '0;
                     rd_in    = '0;
                     j_in     = '0;
                     state_in = B_FLAT;
                  end else begin
                     input_index_in = idx_inc;
                     state_in       = B_IDLE;
                  end
               end else begin
                  q_in = q_next;
                  r_in = r_next;
                  j_in = j_ff + POINT_W'(1);
               end
            end
         end
         B_FLAT: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_last = end_point;
               if (end_point) begin
                  input_index_in  = '0;
                  output_index_in = '0;
                  pos_in          = '0;
                  state_in        = B_IDLE;
               end else begin
                  j_in = j_ff + POINT_W'(1);
               end
            end
         end
         B_NEAR: begin
            if (near_cond) begin
               if (can_emit) begin
                  emit            = 1'b1;
                  emit_val        = sample_ff;
                  emit_last       = near_last;
                  pos_in          = pos_ff + POS_W'(cfg.step);
                  output_index_in = output_index_ff + IDX_W'(1);
                  burst_in        = burst_ff + BURST_W'(1);
               end
            end else begin
               state_in = B_IDLE;
               if (last_ff) begin
                  input_index_in  = '0;
                  output_index_in = '0;
                  pos_in          = '0;
               end else begin
                  input_index_in = input_index_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // output register with 8-bit shaping
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = cfg.out_is_wide ? emit_val
                                         : {{8{emit_val[SAMPLE_W-1]}}, emit_val[SAMPLE_W-1:8]};
         rsp_last_in   = emit_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_sample = rsp_sample_ff;
   assign rsp.out_last   = rsp_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_IDLE;
         j_ff            <= '0;
         burst_ff        <= '0;
         input_index_ff  <= '0;
         output_index_ff <= '0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         j_ff            <= j_in;
         burst_ff        <= burst_in;
         input_index_ff  <= input_index_in;
         output_index_ff <= output_index_in;
         pos_ff          <= pos_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      r_ff          <= r_in;
      qd_ff         <= qd_in;
      rd_ff         <= rd_in;
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef NO_ASSERTIONS
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      input_index_ff <= MAX_IDX)
      else $error("input index beyond sample limit");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INTERP || state_ff == B_FLAT) |-> r_ff < {1'b0, cfg.points})
      else $error("interpolation remainder out of range");
   a_flat_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_FLAT |-> (qd_ff == '0 && rd_ff == '0))
      else $error("flat points with a non-zero step");
`endif

endmodule

### src/audio_sample_rate_converter_unit.sv
// ----------------------------------------------------------------------------
// audio_sample_rate_converter_unit
// Mono PCM resampler: nearest-sample selection with a 4.8 step, or linear
// interpolation with a configured number of points per input.
//
//   channel  direction  payload                 transfer when
//   req      in         in_sample, in_last      req.valid && req.ready
//   rsp      out        out_sample, out_last    rsp.valid && rsp.ready
//   csr_*    in         csr_index, csr_wdata    csr_we
//
// The front takes a new sample only once the last item is in the queue; an
// interpolated linear-mode item first runs the 17-step divider of the sample
// difference. The back gives one output per cycle while rsp does not stall, and
// takes the next item from the queue only after the last one's outputs.
// A two-entry queue lets the front run ahead while the back stalls on rsp.
// Reset is synchronous and leaves no clearing pass; the block is ready next cycle.
// ----------------------------------------------------------------------------
module audio_sample_rate_converter_unit #(
   parameter int MAX_SAMPLES = 1048576,
   parameter int MAX_POINTS  = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   asrc_req_if.sink                          req,
   asrc_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [asrc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [asrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import asrc_pkg::*;

   logic                rate_mode_ff, rate_mode_in;
   logic [STEP_W-1:0]   step_fixed_ff, step_fixed_in;
   logic [POINT_W-1:0]  interp_points_ff, interp_points_in;
   logic                in_is_wide_ff, in_is_wide_in;
   logic                out_is_wide_ff, out_is_wide_in;
   logic [LIMIT_W-1:0]  out_limit_ff, out_limit_in;

   asrc_cfg_type        cfg;
   logic                q_push;
   asrc_entry_type      q_push_entry;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   asrc_entry_type      q_entry;

   // register writes
   always_comb begin
      rate_mode_in     = rate_mode_ff;
      step_fixed_in    = step_fixed_ff;
      interp_points_in = interp_points_ff;
      in_is_wide_in    = in_is_wide_ff;
      out_is_wide_in   = out_is_wide_ff;
      out_limit_in     = out_limit_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RATE_MODE:     rate_mode_in     = csr_wdata[0];
            REG_STEP_FIXED:    step_fixed_in    = csr_wdata[STEP_W-1:0];
            REG_INTERP_POINTS: interp_points_in = csr_wdata[POINT_W-1:0];
            REG_IN_IS_WIDE:    in_is_wide_in    = csr_wdata[0];
            REG_OUT_IS_WIDE:   out_is_wide_in   = csr_wdata[0];
            REG_OUT_LIMIT:     out_limit_in     = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff     <= MODE_NEAREST;
         step_fixed_ff    <= STEP_W'(256);
         interp_points_ff <= POINT_W'(1);
         in_is_wide_ff    <= 1'b1;
         out_is_wide_ff   <= 1'b1;
         out_limit_ff     <= '0;
      end else begin
         rate_mode_ff     <= rate_mode_in;
         step_fixed_ff    <= step_fixed_in;
         interp_points_ff <= interp_points_in;
         in_is_wide_ff    <= in_is_wide_in;
         out_is_wide_ff   <= out_is_wide_in;
         out_limit_ff     <= out_limit_in;
      end
   end

   // effective settings with clamped step and point count
   always_comb begin
      cfg.rate_mode   = rate_mode_ff;
      cfg.in_is_wide  = in_is_wide_ff;
      cfg.out_is_wide = out_is_wide_ff;
      cfg.out_limit   = out_limit_ff;
      cfg.step        = (step_fixed_ff < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP)
                                                            : step_fixed_ff;
      if (interp_points_ff == '0) begin
         cfg.points = POINT_W'(1);
      end else if (interp_points_ff > POINT_W'(MAX_POINTS)) begin
         cfg.points = POINT_W'(MAX_POINTS);
      end else begin
         cfg.points = interp_points_ff;
      end
   end

   asrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full)
   );

   asrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   asrc_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

### tb/audio_sample_rate_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_rate_converter_unit_tb
// Self-checking bench for the mono PCM resampler. A scoreboard predicts the
// output points of every sample transfer in nearest and linear mode, and
// checks them against the rsp channel in order. Directed corner cases come
// first, then random sounds under random register settings and random idling
// on both channels, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module audio_sample_rate_converter_unit_tb;
   import asrc_pkg::*;

   localparam int MAX_SAMPLES  = 1048576;
   localparam int MAX_POINTS   = 32;
   localparam int IDLE_MAX     = 11;
   localparam int QUIET_CYCLES = 80;
   localparam int RANDOM_ITEMS = 310;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } pcm_point_type;

   // predicts output points from sample transfers and checks them in order
   class resample_scoreboard;
      // register mirror
      logic                       rate_mode;
      logic [STEP_W-1:0]          step_fixed;
      logic [POINT_W-1:0]         interp_points;
      logic                       in_is_wide;
      logic                       out_is_wide;
      logic [LIMIT_W-1:0]         out_limit;
      // converter state
      logic [LIMIT_W-1:0]         input_index;
      logic [POS_W-1:0]           position_accum;
      logic [LIMIT_W-1:0]         output_index;
      logic signed [SAMPLE_W-1:0] held_sample;
      logic                       held_valid;
      pcm_point_type              pending_points[$];
      int                         n_errors;
      int                         n_inputs;
      int                         n_outputs;

      function new();
         rate_mode      = MODE_NEAREST;
         step_fixed     = STEP_W'(256);
         interp_points  = POINT_W'(1);
         in_is_wide     = 1'b1;
         out_is_wide    = 1'b1;
         out_limit      = '0;
         input_index    = '0;
         position_accum = '0;
         output_index   = '0;
         held_sample    = '0;
         held_valid     = 1'b0;
         n_errors       = 0;
         n_inputs       = 0;
         n_outputs      = 0;
      endfunction

      // register writes never touch the converter state
      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_RATE_MODE:     rate_mode     = value[0];
            REG_STEP_FIXED:    step_fixed    = value[STEP_W-1:0];
            REG_INTERP_POINTS: interp_points = value[POINT_W-1:0];
            REG_IN_IS_WIDE:    in_is_wide    = value[0];
            REG_OUT_IS_WIDE:   out_is_wide   = value[0];
            REG_OUT_LIMIT:     out_limit     = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // narrow output keeps the arithmetic high byte, sign-extended
      function void push_point(int v, logic last);
         pcm_point_type pt;
         int            r;
         r = out_is_wide ? v : (v >>> 8);
         pt.sample = r[SAMPLE_W-1:0];
         pt.last   = last;
         pending_points.push_back(pt);
      endfunction

      // p points from s1 toward s2, division truncating toward zero
      function void push_ramp(int s1, int s2, int p, logic mark_last);
         for (int j = 0; j < p; j++)
            push_point((s1 * p + (s2 - s1) * j) / p, mark_last && (j == p - 1));
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
         int                 s;
         int                 p;
         int                 step;
         int                 n;
         logic [LIMIT_W-1:0] lim;
         n_inputs++;
         // widen to signed 16 bits; narrow input is offset binary in the low byte
         if (in_is_wide)
            s = $signed(raw);
         else
            s = (int'(raw[7:0]) - 128) * 256;
         if (rate_mode == MODE_LINEAR) begin
            p = interp_points;
            if (p < 1)
               p = 1;
            if (p > MAX_POINTS)
               p = MAX_POINTS;
            if (held_valid)
               push_ramp(held_sample, s, p, 1'b0);
            // end of sound: flat run of the final sample
            if (last) begin
               push_ramp(s, s, p, 1'b1);
               held_valid  = 1'b0;
               held_sample = '0;
            end else begin
               held_sample = s[SAMPLE_W-1:0];
               held_valid  = 1'b1;
            end
            if (input_index < MAX_SAMPLES)
               input_index++;
         end else begin
            step = (step_fixed < MIN_STEP) ? MIN_STEP : step_fixed;
            lim  = (out_limit > LIMIT_W'(MAX_SAMPLES)) ? LIMIT_W'(MAX_SAMPLES) : out_limit;
            // pick this sample for every output whose position lands on it
            if (input_index < MAX_SAMPLES) begin
               n = 0;
               while (n < MAX_BURST && output_index < lim &&
                      (position_accum >> FRAC_W) == input_index) begin
                  push_point(s, output_index == lim - 1'b1);
                  position_accum += step;
                  output_index++;
                  n++;
               end
               input_index++;
            end
         end
         if (last) begin
            input_index    = '0;
            position_accum = '0;
            output_index   = '0;
         end
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] sample, logic last);
         pcm_point_type want;
         n_outputs++;
         if (pending_points.size() == 0) begin
            $error("out_sample: no output expected, got %0d (out_last %0b)",
                   $signed(sample), last);
            n_errors++;
            return;
         end
         want = pending_points.pop_front();
         if (sample !== want.sample) begin
            $error("out_sample: expected %0d, got %0d", $signed(want.sample), $signed(sample));
            n_errors++;
         end
         if (last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, last);
            n_errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   asrc_req_if req_bus ();
   asrc_rsp_if rsp_bus ();

   resample_scoreboard score;
   bit                 calm_req;
   bit                 calm_rsp;
   int                 rsp_hold;

   audio_sample_rate_converter_unit #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_POINTS  (MAX_POINTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // one register write, then the write enable is taken low again
   task automatic csr_write(logic [CSR_ADDR_W-1:0] index, int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      score.write_reg(index, value[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // offer one sample and wait for its transfer
   task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic last);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.in_sample <= sample;
      req_bus.in_last   <= last;
      do @(posedge clock); while (!req_bus.ready);
      score.note_sample(sample, last);
   endtask

   // a sound of random samples with the extremes mixed in
   task automatic send_sound(int len, bit terminated);
      logic [SAMPLE_W-1:0] sample;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       sample = 16'h7FFF;
            1:       sample = 16'h8000;
            default: sample = SAMPLE_W'($urandom_range(0, 65535));
         endcase
         send_sample(sample, terminated && (i == len - 1));
      end
   endtask

   // drop valid, wait for every expected point, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (score.pending_points.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            hold     = rsp_hold;
            rsp_hold = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = calm_rsp ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         score.check_output(rsp_bus.out_sample, rsp_bus.out_last);
      end
   end

   // stimulus
   initial begin
      int mode;
      int step;
      int limit;
      int pts;
      int len;
      int n_random;
      int n_configs;
      int n_linear;
      score     = new();
      calm_req  = 1'b0;
      calm_rsp  = 1'b0;
      rsp_hold  = 0;
      n_random  = 0;
      n_configs = 0;
      n_linear  = 0;
      req_bus.valid     <= 1'b0;
      req_bus.in_sample <= '0;
      req_bus.in_last   <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // nearest with the reset limit of zero: nothing comes out
      send_sample(16'h1234, 1'b0);
      send_sample(16'hABCD, 1'b1);
      settle();

      // equal-rate copy, limit reached before the end of the sound
      csr_write(REG_OUT_LIMIT, 4);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h5555, 1'b1);
      settle();

      // narrow in and out, step below the minimum gives full bursts
      csr_write(REG_IN_IS_WIDE, 0);
      csr_write(REG_OUT_IS_WIDE, 0);
      csr_write(REG_STEP_FIXED, 0);
      csr_write(REG_OUT_LIMIT, 200);
      send_sample(16'hFF00, 1'b0);
      send_sample(16'h00FF, 1'b0);
      send_sample(16'h1280, 1'b1);
      settle();

      // widest step, limit above the sample maximum
      csr_write(REG_IN_IS_WIDE, 1);
      csr_write(REG_STEP_FIXED, 4095);
      csr_write(REG_OUT_LIMIT, 21'h1FFFFF);
      send_sample(16'h8001, 1'b0);
      send_sample(16'h7FFE, 1'b1);
      settle();

      // linear with zero points: first sample only held
      csr_write(REG_RATE_MODE, MODE_LINEAR);
      csr_write(REG_INTERP_POINTS, 0);
      csr_write(REG_OUT_IS_WIDE, 1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0001, 1'b1);
      settle();

      // point count above the maximum, a one-sample sound, full-swing ramp
      csr_write(REG_INTERP_POINTS, 63);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      settle();

      // narrow input bytes at both ends
      csr_write(REG_IN_IS_WIDE, 0);
      csr_write(REG_INTERP_POINTS, 32);
      send_sample(16'hAB00, 1'b0);
      send_sample(16'h00FF, 1'b1);
      settle();

      // truncation of a negative ramp, then a mode change within the sound
      csr_write(REG_IN_IS_WIDE, 1);
      csr_write(REG_INTERP_POINTS, 3);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFF9, 1'b0);
      settle();
      csr_write(REG_RATE_MODE, MODE_NEAREST);
      csr_write(REG_STEP_FIXED, 256);
      csr_write(REG_OUT_LIMIT, 3);
      send_sample(16'h4000, 1'b1);
      settle();

      // long receiver hold-off while samples keep coming back to back
      csr_write(REG_RATE_MODE, MODE_LINEAR);
      csr_write(REG_INTERP_POINTS, 32);
      calm_req = 1'b1;
      rsp_hold = 300;
      send_sound(12, 1'b1);
      settle();

      // random sounds under random settings
      while (n_random < RANDOM_ITEMS) begin
         calm_req = ($urandom_range(0, 3) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         mode     = $urandom_range(0, 1);
         len      = $urandom_range(1, 12);
         csr_write(REG_RATE_MODE, mode);
         if ($urandom_range(0, 2) == 0)
            csr_write(REG_IN_IS_WIDE, $urandom_range(0, 1));
         if ($urandom_range(0, 2) == 0)
            csr_write(REG_OUT_IS_WIDE, $urandom_range(0, 1));
         if (mode == MODE_LINEAR) begin
            case ($urandom_range(0, 9))
               0:       pts = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
               1:       pts = $urandom_range(9, 32);
               default: pts = $urandom_range(1, 8);
            endcase
            csr_write(REG_INTERP_POINTS, pts);
            n_linear++;
         end else begin
            case ($urandom_range(0, 9))
               0:       step = $urandom_range(0, 63);
               1:       step = $urandom_range(641, 4095);
               default: step = $urandom_range(64, 640);
            endcase
            csr_write(REG_STEP_FIXED, step);
            if (step < MIN_STEP)
               step = MIN_STEP;
            case ($urandom_range(0, 9))
               0:       limit = 0;
               1:       limit = $urandom_range(MAX_SAMPLES, 2 ** LIMIT_W - 1);
               default: limit = $urandom_range(1, len * 256 / step + 2);
            endcase
            csr_write(REG_OUT_LIMIT, limit);
         end
         // now and then a sound is left open across the next settings
         send_sound(len, $urandom_range(0, 7) != 0);
         n_random += len;
         n_configs++;
         settle();
      end

      $display("covered %0d sample transfers and %0d output transfers", score.n_inputs,
               score.n_outputs);
      $display("random part: %0d settings, %0d linear and %0d nearest", n_configs, n_linear,
               n_configs - n_linear);
      if (score.n_errors == 0 && score.pending_points.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
